FILE: design/cbf_pkg.sv
`default_nettype none

package cbf_pkg;

    localparam int DEPTH     = 256;
    localparam int MAX_FETCH = 64;

    // Longest ring that the indices can address.
    localparam int LEN_TOP = (DEPTH < 256) ? DEPTH : 256;
    localparam int IDX_W   = $clog2(LEN_TOP);
    localparam int LEN_W   = IDX_W + 1;
    localparam int CNT_W   = $clog2(MAX_FETCH + 1);

    localparam int OPC_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 9;
    localparam int FCNT_W = 7;
    localparam int STAT_W = 3;

    typedef enum logic [OPC_W-1:0] {
        OP_STORE   = 3'd0,
        OP_BURST   = 3'd1,
        OP_FETCH   = 3'd2,
        OP_FETCH_N = 3'd3,
        OP_FLUSH   = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_NODATA  = 3'd4,
        ST_DROPPED = 3'd5
    } t_status;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] data_out;
        logic              last;
        logic [BYTE_W-1:0] data_count;
        logic [BYTE_W-1:0] free_count;
    } t_result;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] x,
                                                 input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] sum;
        sum = {1'b0, x} + LEN_W'(1);
        return (sum >= len) ? '0 : sum[IDX_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] f_held(input logic [IDX_W-1:0] w,
                                                 input logic [IDX_W-1:0] r,
                                                 input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] diff;
        if (w >= r) begin
            diff = {1'b0, w} - {1'b0, r};
        end else begin
            diff = {1'b0, w} + len - {1'b0, r};
        end
        return diff;
    endfunction

endpackage

`default_nettype wire

FILE: design/cbf_if.sv
`default_nettype none

interface cbf_in_if;
    logic                             valid;
    logic                             ready;
    logic [cbf_pkg::OPC_W-1:0]        opcode;
    logic [cbf_pkg::BYTE_W-1:0]       data_in;
    logic                             burst_first;
    logic [cbf_pkg::BYTE_W-1:0]       burst_len;
    logic [cbf_pkg::FCNT_W-1:0]       fetch_count;

    modport source (output valid, opcode, data_in, burst_first, burst_len, fetch_count,
                    input ready);
    modport sink (input valid, opcode, data_in, burst_first, burst_len, fetch_count,
                  output ready);
endinterface

interface cbf_out_if;
    logic                             valid;
    logic                             ready;
    logic [cbf_pkg::STAT_W-1:0]       status;
    logic [cbf_pkg::BYTE_W-1:0]       data_out;
    logic                             last;
    logic [cbf_pkg::BYTE_W-1:0]       data_count;
    logic [cbf_pkg::BYTE_W-1:0]       free_count;

    modport source (output valid, status, data_out, last, data_count, free_count,
                    input ready);
    modport sink (input valid, status, data_out, last, data_count, free_count,
                  output ready);
endinterface

interface cbf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cbf_pkg::CFG_W-1:0]        ring_length;

    modport source (output valid, ring_length, input ready);
    modport sink (input valid, ring_length, output ready);
endinterface

`default_nettype wire

FILE: design/cbf_ram.sv
`default_nettype none

module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/cbf_ctrl.sv
`default_nettype none

module cbf_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    cbf_in_if.sink                      i_in,
    cbf_out_if.source                   o_out,
    cbf_cfg_if.sink                     i_cfg,
    output cbf_pkg::t_ram_req           o_ram,
    input  wire logic [cbf_pkg::BYTE_W-1:0] i_rdata
);

    import cbf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_w, n_w;
    logic [IDX_W-1:0]  r_r, n_r;
    logic              r_rej, n_rej;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_out_valid, n_out_valid;
    t_result           r_res, n_res;

    logic              slot_free;
    logic              in_acc;
    logic              cfg_acc;
    logic              load;
    t_status           res_status;
    logic [BYTE_W-1:0] res_data;
    logic              res_last;
    logic [IDX_W-1:0]  w_nxt;
    logic              full;
    logic [LEN_W-1:0]  held_now;
    logic [LEN_W-1:0]  room_now;
    logic [LEN_W-1:0]  held_new;
    logic [LEN_W-1:0]  room_new;
    logic [CNT_W-1:0]  cnt;
    logic [LEN_W-1:0]  cfg_len;
    t_ram_req          ram;

    // A result register sits between the sequencer and the output handshake.
    // A length write is taken only between requests and holds off a new one.
    assign slot_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && slot_free && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign cfg_acc    = i_cfg.valid && i_cfg.ready;

    assign w_nxt    = f_next(r_w, r_len);
    assign full     = (w_nxt == r_r);
    assign held_now = f_held(r_w, r_r, r_len);
    assign room_now = r_len - LEN_W'(1) - held_now;
    assign cnt      = (CNT_W'(i_in.fetch_count) > CNT_W'(MAX_FETCH) ||
                       i_in.fetch_count > FCNT_W'(MAX_FETCH))
                      ? CNT_W'(MAX_FETCH) : CNT_W'(i_in.fetch_count);

    always_comb begin
        if (i_cfg.ring_length < CFG_W'(2)) begin
            cfg_len = LEN_W'(2);
        end else if (i_cfg.ring_length > CFG_W'(LEN_TOP)) begin
            cfg_len = LEN_W'(LEN_TOP);
        end else begin
            cfg_len = LEN_W'(i_cfg.ring_length);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_w        = r_w;
        n_r        = r_r;
        n_rej      = r_rej;
        n_len      = r_len;
        n_left     = r_left;
        ram        = '0;
        load       = 1'b0;
        res_status = ST_OK;
        res_data   = '0;
        res_last   = 1'b1;

        if (cfg_acc) begin
            n_len = cfg_len;
            n_w   = '0;
            n_r   = '0;
            n_rej = 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in.opcode)
                            OP_STORE, OP_BURST: begin
                                load = 1'b1;
                                if (i_in.opcode == OP_BURST && i_in.burst_first &&
                                    LEN_W'(i_in.burst_len) > room_now) begin
                                    n_rej      = 1'b1;
                                    res_status = ST_NOSPACE;
                                end else if (i_in.opcode == OP_BURST &&
                                             !i_in.burst_first && r_rej) begin
                                    res_status = ST_DROPPED;
                                end else begin
                                    if (i_in.opcode == OP_BURST && i_in.burst_first) begin
                                        n_rej = 1'b0;
                                    end
                                    if (full) begin
                                        res_status = ST_FULL;
                                    end else begin
                                        ram.we    = 1'b1;
                                        ram.waddr = r_w;
                                        ram.wdata = i_in.data_in;
                                        n_w       = w_nxt;
                                    end
                                end
                            end
                            OP_FETCH: begin
                                if (held_now == '0) begin
                                    load       = 1'b1;
                                    res_status = ST_EMPTY;
                                end else begin
                                    ram.re  = 1'b1;
                                    ram.raddr = r_r;
                                    n_left  = CNT_W'(1);
                                    n_state = S_FETCH;
                                end
                            end
                            OP_FETCH_N: begin
                                if (cnt == '0) begin
                                    load = 1'b1;
                                end else if (held_now < LEN_W'(cnt)) begin
                                    load       = 1'b1;
                                    res_status = ST_NODATA;
                                end else begin
                                    ram.re    = 1'b1;
                                    ram.raddr = r_r;
                                    n_left    = cnt;
                                    n_state   = S_FETCH;
                                end
                            end
                            OP_FLUSH: begin
                                load  = 1'b1;
                                n_w   = '0;
                                n_r   = '0;
                                n_rej = 1'b0;
                            end
                            default: begin
                                load = 1'b1;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    // The byte last read waits in the RAM output register until the
                    // result register can take it.
                    if (slot_free) begin
                        load     = 1'b1;
                        res_data = i_rdata;
                        res_last = (r_left == CNT_W'(1));
                        n_r      = f_next(r_r, r_len);
                        n_left   = r_left - CNT_W'(1);
                        if (r_left == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end else begin
                            ram.re    = 1'b1;
                            ram.raddr = n_r;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    assign held_new = f_held(n_w, n_r, n_len);
    assign room_new = n_len - LEN_W'(1) - held_new;

    always_comb begin
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_out.ready;
        if (load) begin
            n_out_valid      = 1'b1;
            n_res.status     = res_status;
            n_res.data_out   = res_data;
            n_res.last       = res_last;
            n_res.data_count = held_new[BYTE_W-1:0];
            n_res.free_count = room_new[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_w         <= '0;
            r_r         <= '0;
            r_rej       <= 1'b0;
            r_len       <= LEN_W'(LEN_TOP);
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_w         <= n_w;
            r_r         <= n_r;
            r_rej       <= n_rej;
            r_len       <= n_len;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_ram            = ram;
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_res.status;
    assign o_out.data_out   = r_res.data_out;
    assign o_out.last       = r_res.last;
    assign o_out.data_count = r_res.data_count;
    assign o_out.free_count = r_res.free_count;

`ifndef SYNTHESIS
    a_idx_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_w} < r_len) && ({1'b0, r_r} < r_len))
        else $error("ring index beyond the configured length");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held_now < r_len)
        else $error("held count exceeds capacity");

    a_fetch_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_left != '0))
        else $error("fetch sequence running with nothing left");

    a_fetch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FETCH) && slot_free && (r_left == CNT_W'(1)))
        |=> (r_state == S_IDLE) && r_out_valid && o_out.last)
        else $error("final fetched byte not marked last");

    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram.we |-> !cfg_acc && (n_w != r_w))
        else $error("store written without advancing the write index");
`endif

endmodule

`default_nettype wire

FILE: design/circular_byte_fifo_unit.sv
`default_nettype none

// Byte ring FIFO of up to 255 bytes (ring_length - 1) with single and burst
// stores, single and counted fetches, and flush; each request yields one
// result, a counted fetch of N bytes yields N. Store, flush and rejected
// requests are taken at one per cycle while the result register drains.
// A fetched byte comes from a RAM with a registered read, so a single or
// counted fetch holds the unit in its fetch state until its last byte is in
// the result register, and no new request is taken meanwhile. Writing
// ring_length empties the ring; no clearing pass is needed after reset.
module circular_byte_fifo_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cbf_in_if.sink    i_in,
    cbf_out_if.source o_out,
    cbf_cfg_if.sink   i_cfg
);

    import cbf_pkg::*;

    t_ram_req          ram;
    logic [BYTE_W-1:0] rdata;

    cbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .o_ram   (ram),
        .i_rdata (rdata)
    );

    cbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LEN_TOP)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbf_pkg::*;

    localparam int SETTLE     = 4;
    localparam int END_WAIT   = 20;
    localparam int LIMIT      = 1_500_000;
    localparam int PHASE_REQS = 25;
    localparam int MAX_REPORTS = 200;

    localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [CFG_W-1:0] LEN_RESET   = 9'd256;

    typedef struct {
        bit                is_cfg;
        logic [CFG_W-1:0]  len;
        logic [OPC_W-1:0]  opcode;
        logic [BYTE_W-1:0] data;
        logic              is_first;
        logic [BYTE_W-1:0] blen;
        logic [FCNT_W-1:0] cnt;
        int                gap;
    } t_bus_op;

    logic clk;
    logic rst_n;

    cbf_in_if  in_bus ();
    cbf_out_if out_bus ();
    cbf_cfg_if cfg_bus ();

    circular_byte_fifo_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always #5 clk = ~clk;

    // Requests and length writes waiting to be driven, and results still owed.
    t_bus_op pending_reqs[$];
    t_result expected_results[$];

    // Shadow of the ring, updated at every accepted request or length write.
    logic [BYTE_W-1:0] ring_mem [0:LEN_TOP-1];
    logic [CFG_W-1:0]  ring_len      = LEN_RESET;
    int                wr_ptr        = 0;
    int                rd_ptr        = 0;
    bit                burst_refused = 1'b0;

    // Occupancy as the stimulus plan expects it, so that fetches can be sized.
    int plan_level   = 0;
    int plan_cap     = LEN_RESET - 1;
    bit plan_refused = 1'b0;
    bit plan_calm    = 1'b0;

    bit req_taken = 1'b0;
    bit cfg_taken = 1'b0;
    bit res_taken = 1'b0;
    bit in_busy   = 1'b0;
    bit cfg_busy  = 1'b0;
    bit gap_armed = 1'b0;
    int gap_left  = 0;
    int quiet_left = SETTLE;
    t_bus_op next_op;

    int sink_wait = 0;
    int sink_run  = 0;
    bit sink_calm = 1'b0;

    int fail_count  = 0;
    int req_count   = 0;
    int cfg_count   = 0;
    int res_count   = 0;
    int cycle_count = 0;
    int status_hits [0:ST_DROPPED];

    function automatic int span_of(input logic [CFG_W-1:0] len);
        int n;
        n = len;
        if (n < 2) n = 2;
        if (n > LEN_TOP) n = LEN_TOP;
        return n;
    endfunction

    function automatic int ring_step(input int idx);
        return (idx + 1 >= span_of(ring_len)) ? 0 : idx + 1;
    endfunction

    function automatic int ring_held();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + span_of(ring_len) - rd_ptr;
    endfunction

    function automatic int ring_room();
        return span_of(ring_len) - 1 - ring_held();
    endfunction

    function automatic t_status ring_put(input logic [BYTE_W-1:0] d);
        if (ring_step(wr_ptr) == rd_ptr) return ST_FULL;
        ring_mem[wr_ptr] = d;
        wr_ptr = ring_step(wr_ptr);
        return ST_OK;
    endfunction

    function automatic logic [BYTE_W-1:0] ring_take();
        logic [BYTE_W-1:0] d;
        d = ring_mem[rd_ptr];
        rd_ptr = ring_step(rd_ptr);
        return d;
    endfunction

    function automatic void ring_clear();
        wr_ptr = 0;
        rd_ptr = 0;
        burst_refused = 1'b0;
    endfunction

    // Counts are taken after the byte of this result has gone in or out.
    function automatic void owe_result(input t_status st, input logic [BYTE_W-1:0] d,
                                       input logic is_last);
        t_result r;
        r.status     = st;
        r.data_out   = d;
        r.last       = is_last;
        r.data_count = BYTE_W'(ring_held());
        r.free_count = BYTE_W'(ring_room());
        expected_results.push_back(r);
    endfunction

    function automatic void fifo_apply(input logic [OPC_W-1:0] opc,
                                       input logic [BYTE_W-1:0] din,
                                       input logic is_first,
                                       input logic [BYTE_W-1:0] blen,
                                       input logic [FCNT_W-1:0] cnt);
        int n;
        t_status st;
        logic [BYTE_W-1:0] d;
        case (opc)
            OP_STORE: begin
                owe_result(ring_put(din), '0, 1'b1);
            end
            OP_BURST: begin
                if (is_first) begin
                    if (blen > ring_room()) begin
                        burst_refused = 1'b1;
                        st = ST_NOSPACE;
                    end else begin
                        burst_refused = 1'b0;
                        st = ring_put(din);
                    end
                end else if (burst_refused) begin
                    st = ST_DROPPED;
                end else begin
                    st = ring_put(din);
                end
                owe_result(st, '0, 1'b1);
            end
            OP_FETCH: begin
                if (ring_held() == 0) begin
                    owe_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    d = ring_take();
                    owe_result(ST_OK, d, 1'b1);
                end
            end
            OP_FETCH_N: begin
                n = (cnt > MAX_FETCH) ? MAX_FETCH : cnt;
                if (n == 0) begin
                    owe_result(ST_OK, '0, 1'b1);
                end else if (ring_held() < n) begin
                    owe_result(ST_NODATA, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        d = ring_take();
                        owe_result(ST_OK, d, i == n - 1);
                    end
                end
            end
            OP_FLUSH: begin
                ring_clear();
                owe_result(ST_OK, '0, 1'b1);
            end
            default: begin
                owe_result(ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [FCNT_W-1:0] rand_cnt();
        return FCNT_W'($urandom_range(0, 127));
    endfunction

    task automatic add_req(input logic [OPC_W-1:0] opc, input logic [BYTE_W-1:0] din,
                           input logic is_first, input logic [BYTE_W-1:0] blen,
                           input logic [FCNT_W-1:0] cnt);
        t_bus_op op;
        int n;
        op.is_cfg   = 1'b0;
        op.len      = '0;
        op.opcode   = opc;
        op.data     = din;
        op.is_first = is_first;
        op.blen     = blen;
        op.cnt      = cnt;
        op.gap      = plan_calm ? 0 : $urandom_range(0, 9);
        pending_reqs.push_back(op);
        case (opc)
            OP_STORE: if (plan_level < plan_cap) plan_level++;
            OP_BURST: begin
                if (is_first) begin
                    if (blen > plan_cap - plan_level) begin
                        plan_refused = 1'b1;
                    end else begin
                        plan_refused = 1'b0;
                        if (plan_level < plan_cap) plan_level++;
                    end
                end else if (!plan_refused && plan_level < plan_cap) begin
                    plan_level++;
                end
            end
            OP_FETCH: if (plan_level > 0) plan_level--;
            OP_FETCH_N: begin
                n = (cnt > MAX_FETCH) ? MAX_FETCH : cnt;
                if (n <= plan_level) plan_level -= n;
            end
            OP_FLUSH: begin
                plan_level   = 0;
                plan_refused = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic add_cfg(input logic [CFG_W-1:0] len);
        t_bus_op op;
        op.is_cfg   = 1'b1;
        op.len      = len;
        op.opcode   = '0;
        op.data     = '0;
        op.is_first = 1'b0;
        op.blen     = '0;
        op.cnt      = '0;
        op.gap      = $urandom_range(0, 9);
        pending_reqs.push_back(op);
        plan_level   = 0;
        plan_refused = 1'b0;
        plan_cap     = span_of(len) - 1;
    endtask

    // Mostly stores, well-formed bursts and fetches sized to what the ring holds, with a
    // share of refused bursts, stray burst bytes, odd counts, flushes and spare opcodes.
    task automatic plan_random(inout int counted);
        int roll;
        int room;
        int blen;
        int nlater;
        int top;
        int n;
        if ($urandom_range(0, 15) == 0) plan_calm = !plan_calm;
        roll = $urandom_range(0, 99);
        room = plan_cap - plan_level;
        if (roll < 30) begin
            add_req(OP_STORE, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(), rand_cnt());
            counted++;
        end else if (roll < 50) begin
            if (room > 0 && $urandom_range(0, 4) != 0) begin
                top    = (room < 12) ? room : 12;
                blen   = $urandom_range(1, top);
                nlater = blen - 1;
                if ($urandom_range(0, 5) == 0) nlater = $urandom_range(0, blen + 2);
            end else begin
                blen   = (room >= 255) ? 0 : $urandom_range(room + 1, 255);
                nlater = $urandom_range(0, 3);
            end
            add_req(OP_BURST, rand_byte(), 1'b1, BYTE_W'(blen), rand_cnt());
            counted++;
            repeat (nlater) begin
                add_req(OP_BURST, rand_byte(), 1'b0, rand_byte(), rand_cnt());
                if (!plan_refused) counted++;
            end
        end else if (roll < 65) begin
            add_req(OP_FETCH, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(), rand_cnt());
            counted++;
        end else if (roll < 85) begin
            if (plan_level > 0 && $urandom_range(0, 4) != 0) begin
                top = (plan_level < MAX_FETCH) ? plan_level : MAX_FETCH;
                n   = $urandom_range(1, top);
            end else begin
                n = $urandom_range(0, 127);
            end
            add_req(OP_FETCH_N, rand_byte(), 1'b0, rand_byte(), FCNT_W'(n));
            counted++;
        end else if (roll < 92) begin
            if ($urandom_range(0, 1) == 0) begin
                add_req(OP_BURST, rand_byte(), 1'b0, rand_byte(), rand_cnt());
            end else begin
                add_req(OP_FETCH_N, rand_byte(), 1'b1, rand_byte(), rand_cnt());
            end
            counted++;
        end else if (roll < 96) begin
            add_req(OP_FLUSH, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(), rand_cnt());
            counted++;
        end else begin
            add_req(OPC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), rand_byte(),
                    1'($urandom_range(0, 1)), rand_byte(), rand_cnt());
        end
    endtask

    task automatic check_result();
        t_result seen;
        t_result want;
        seen.status     = t_status'(out_bus.status);
        seen.data_out   = out_bus.data_out;
        seen.last       = out_bus.last;
        seen.data_count = out_bus.data_count;
        seen.free_count = out_bus.free_count;
        res_count++;
        if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: result with none owed: status %0d data %02h last %0b",
                         $time, seen.status, seen.data_out, seen.last);
        end else begin
            want = expected_results.pop_front();
            status_hits[want.status]++;
            if (seen.status !== want.status || seen.data_out !== want.data_out ||
                seen.last !== want.last || seen.data_count !== want.data_count ||
                seen.free_count !== want.free_count) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $write("%0t: expected status %0d data %02h last %0b count %0d free %0d,",
                           $time, want.status, want.data_out, want.last, want.data_count,
                           want.free_count);
                    $display(" got status %0d data %02h last %0b count %0d free %0d",
                             seen.status, seen.data_out, seen.last,
                             seen.data_count, seen.free_count);
                end
            end
        end
    endtask

    // Results are checked before the request of the same edge is predicted:
    // a result can never belong to a request accepted at that very edge.
    always @(posedge clk) begin
        req_taken = rst_n && in_bus.valid && in_bus.ready;
        cfg_taken = rst_n && cfg_bus.valid && cfg_bus.ready;
        res_taken = rst_n && out_bus.valid && out_bus.ready;
        if (res_taken) check_result();
        if (cfg_taken) begin
            ring_len = cfg_bus.ring_length;
            ring_clear();
            cfg_count++;
        end
        if (req_taken) begin
            fifo_apply(in_bus.opcode, in_bus.data_in, in_bus.burst_first, in_bus.burst_len,
                       in_bus.fetch_count);
            req_count++;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // A length write waits until every owed result is in and the quiet
    // countdown from SETTLE has run out.
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_busy && req_taken) in_busy = 1'b0;
            if (cfg_busy && cfg_taken) cfg_busy = 1'b0;
            if (expected_results.size() != 0) begin
                quiet_left = SETTLE;
            end else if (quiet_left > 0) begin
                quiet_left--;
            end
            if (!in_busy && !cfg_busy && pending_reqs.size() != 0) begin
                if (!gap_armed) begin
                    gap_left  = pending_reqs[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!pending_reqs[0].is_cfg) begin
                    next_op = pending_reqs.pop_front();
                    in_bus.opcode      <= next_op.opcode;
                    in_bus.data_in     <= next_op.data;
                    in_bus.burst_first <= next_op.is_first;
                    in_bus.burst_len   <= next_op.blen;
                    in_bus.fetch_count <= next_op.cnt;
                    in_busy   = 1'b1;
                    gap_armed = 1'b0;
                end else if (expected_results.size() == 0 && quiet_left == 0) begin
                    next_op = pending_reqs.pop_front();
                    cfg_bus.ring_length <= next_op.len;
                    cfg_busy  = 1'b1;
                    gap_armed = 1'b0;
                end
            end
            in_bus.valid  <= in_busy;
            cfg_bus.valid <= cfg_busy;
        end
    end

    // The result side may stall after each result it takes, in runs that are
    // either calm (no stall) or busy.
    always @(negedge clk) begin
        if (rst_n) begin
            if (res_taken) begin
                if (sink_run == 0) begin
                    sink_run  = $urandom_range(10, 40);
                    sink_calm = ($urandom_range(0, 3) == 0);
                end
                sink_run--;
                sink_wait = sink_calm ? 0 : $urandom_range(0, 9);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            out_bus.ready <= (sink_wait == 0);
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_lens [12];
        int phase_count;

        clk   = 1'b0;
        rst_n = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.opcode       = '0;
        in_bus.data_in      = '0;
        in_bus.burst_first  = 1'b0;
        in_bus.burst_len    = '0;
        in_bus.fetch_count  = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.ring_length = '0;
        out_bus.ready       = 1'b0;
        foreach (status_hits[i]) status_hits[i] = 0;

        // Directed part at the reset length of 256.
        add_req(OP_FETCH,   8'h00, 1'b0, 8'd0,   7'd0);
        add_req(OP_FETCH_N, 8'h00, 1'b0, 8'd0,   7'd0);
        add_req(OP_FETCH_N, 8'h00, 1'b0, 8'd0,   7'd5);
        add_req(OP_STORE,   8'h00, 1'b0, 8'd0,   7'd0);
        add_req(OP_STORE,   8'hFF, 1'b1, 8'hFF,  7'h7F);
        add_req(OP_STORE,   8'hA5, 1'b0, 8'd0,   7'd0);
        add_req(OP_FETCH,   8'h00, 1'b0, 8'd0,   7'd0);
        add_req(OP_FETCH_N, 8'h00, 1'b0, 8'd0,   7'd2);
        add_req(OP_BURST,   8'h3C, 1'b1, 8'd0,   7'd0);
        add_req(OP_BURST,   8'h11, 1'b1, 8'd255, 7'd0);
        add_req(OP_BURST,   8'h22, 1'b0, 8'd0,   7'd0);
        add_req(OP_STORE,   8'h5A, 1'b0, 8'd0,   7'd0);
        add_req(OP_BURST,   8'h33, 1'b0, 8'd0,   7'd0);
        add_req(OP_FETCH_N, 8'h00, 1'b0, 8'd0,   7'd127);
        add_req(OP_SPARE_LO, 8'hC3, 1'b1, 8'd7,  7'd3);
        add_req(OP_SPARE_HI, 8'h3C, 1'b0, 8'd9,  7'd64);
        add_req(OP_FLUSH,   8'h00, 1'b0, 8'd0,   7'd0);
        add_req(OP_BURST,   8'h44, 1'b0, 8'd0,   7'd0);

        // A ring of four slots: burst exactly filling it, then full and too-long cases.
        add_cfg(9'd4);
        add_req(OP_BURST,   8'h01, 1'b1, 8'd3,   7'd0);
        add_req(OP_BURST,   8'h02, 1'b0, 8'd0,   7'd0);
        add_req(OP_BURST,   8'h03, 1'b0, 8'd0,   7'd0);
        add_req(OP_STORE,   8'h04, 1'b0, 8'd0,   7'd0);
        add_req(OP_BURST,   8'h05, 1'b0, 8'd0,   7'd0);
        add_req(OP_FETCH_N, 8'h00, 1'b0, 8'd0,   7'd3);
        add_req(OP_BURST,   8'h06, 1'b1, 8'd4,   7'd0);

        phase_lens = '{9'd3, 9'd0, 9'd17, 9'd511, 9'd2, 9'd64,
                       9'd1, 9'd256, 9'd300, 9'd9, 9'd130, 9'd0};
        phase_lens[11] = CFG_W'($urandom_range(2, 256));
        foreach (phase_lens[p]) begin
            add_cfg(phase_lens[p]);
            phase_count = 0;
            while (phase_count < PHASE_REQS) plan_random(phase_count);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_reqs.size() != 0 || in_busy || cfg_busy ||
               expected_results.size() != 0) @(negedge clk);
        repeat (END_WAIT) @(negedge clk);

        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        $display("Ran %0d requests and %0d results over %0d ring length writes.",
                 req_count, res_count, cfg_count);
        $display("Outcomes: ok %0d, full %0d, no space %0d, empty %0d, no data %0d, dropped %0d.",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_NOSPACE],
                 status_hits[ST_EMPTY], status_hits[ST_NODATA], status_hits[ST_DROPPED]);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
design/cbf_pkg.sv
design/cbf_if.sv
design/cbf_ram.sv
design/cbf_ctrl.sv
design/circular_byte_fifo_unit.sv
tb/tb_top.sv
